// ===== hdl/fds_pkg.sv =====
// Package: request and result payload types, status codes and fixed widths.
package fds_pkg;

    localparam int WORD_BITS = 32;
    localparam int CFG_BITS  = 16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_RATE = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_ZERO_DEN  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic REQ_SOLVE  = 1'b0;
    localparam logic REQ_RECALC = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] target_rate;
        logic [31:0] base_rate;
        logic [31:0] reg_word;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] numerator;
        logic [15:0] denominator;
        logic [31:0] packed_word;
        logic [31:0] out_rate;
    } t_res;

endpackage

// ===== hdl/fractional_divider_setting_solver.sv =====
// Fractional divider setting solver: Euclid reduction and rate recalculation.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------
//  request | in        | i_in_valid / o_in_ready    | i_in_data
//  result  | out       | o_out_valid / i_out_ready  | o_out_data
//  config  | in        | i_cfg_we                   | i_cfg_wdata
//
// One shared restoring divider (one quotient bit per cycle) does every modulo and
// division. Solve takes one pass per Euclid step plus two divisions and a
// multiply/compare; recalc takes one multiply and one pass. Zero-rate, zero-word
// and zero-denominator requests skip the divider and go from idle straight to the
// output state. Reset returns the sequencer to idle and min_ratio to 20. A waiting
// result stalls only the loading of the next one.
module fractional_divider_setting_solver
    import fds_pkg::*;
#(
    parameter int RATE_BITS  = 32,
    parameter int FIELD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_req                i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_res                o_out_data,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    localparam int F   = FIELD_BITS;
    localparam int W   = WORD_BITS;
    localparam int DW  = W + F;
    localparam int CW  = $clog2(DW + 1);
    localparam logic [63:0] MASK64 = (64'd1 << RATE_BITS) - 64'd1;
    localparam logic [W-1:0] RATE_MASK = MASK64[W-1:0];
    localparam logic [W-1:0] FIELD_MAX = W'((64'd1 << F) - 64'd1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GCD  = 4'd1;
    localparam logic [3:0] S_DIVN = 4'd2;
    localparam logic [3:0] S_DIVD = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_RMUL = 4'd6;
    localparam logic [3:0] S_RDIV = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]          r_state;
    logic [CFG_BITS-1:0] r_min_ratio;
    logic [W-1:0]        r_tgt, r_par, r_n;
    logic [F-1:0]        r_num, r_den;
    logic [2:0]          r_status;
    logic [W-1:0]        r_rate;
    logic [CFG_BITS+F-1:0] r_prod;
    logic [W-1:0]        r_rem, r_dvs;
    logic [DW-1:0]       r_quo;
    logic [CW-1:0]       r_cnt;
    logic                r_ovalid;
    t_res                r_out;

    // divider step
    logic [W:0]   s_trial;
    logic         s_qbit;
    logic [W-1:0] s_rem;
    logic         s_busy;
    logic [F-1:0] s_wnum, s_wden;
    logic [DW-1:0] s_limq;

    assign s_trial = {r_rem, r_quo[DW-1]};
    assign s_qbit  = (s_trial >= {1'b0, r_dvs});
    assign s_rem   = s_qbit ? W'(s_trial - {1'b0, r_dvs}) : s_trial[W-1:0];
    assign s_busy  = (r_cnt != '0);
    assign s_wnum  = i_in_data.reg_word[2*F-1:F];
    assign s_wden  = i_in_data.reg_word[F-1:0];
    assign s_limq  = DW'(RATE_MASK);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ratio <= CFG_BITS'(20);
        end else if (i_cfg_we) begin
            r_min_ratio <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            if (s_busy) begin
                r_rem <= s_rem;
                r_quo <= {r_quo[DW-2:0], s_qbit};
                r_cnt <= r_cnt - CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tgt    <= i_in_data.target_rate & RATE_MASK;
                        r_par    <= i_in_data.base_rate & RATE_MASK;
                        r_status <= ST_OK;
                        r_num    <= '0;
                        r_den    <= '0;
                        r_rate   <= '0;
                        if (i_in_data.req_type == REQ_SOLVE) begin
                            if ((i_in_data.target_rate & RATE_MASK) == '0 ||
                                (i_in_data.base_rate & RATE_MASK) == '0) begin
                                r_status <= ST_ZERO_RATE;
                                r_state  <= S_OUT;
                            end else begin
                                r_rem   <= '0;
                                r_quo   <= DW'(i_in_data.target_rate & RATE_MASK);
                                r_dvs   <= i_in_data.base_rate & RATE_MASK;
                                r_cnt   <= CW'(DW);
                                r_state <= S_GCD;
                            end
                        end else if (i_in_data.reg_word == '0) begin
                            r_rate  <= i_in_data.base_rate & RATE_MASK;
                            r_state <= S_OUT;
                        end else begin
                            r_num <= s_wnum;
                            r_den <= s_wden;
                            if (s_wden == '0) begin
                                r_status <= ST_ZERO_DEN;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_RMUL;
                            end
                        end
                    end
                end
                S_GCD: begin
                    if (!s_busy) begin
                        r_rem <= '0;
                        r_cnt <= CW'(DW);
                        if (r_rem == '0) begin
                            // gcd is the current divisor
                            r_quo   <= DW'(r_tgt);
                            r_state <= S_DIVN;
                        end else begin
                            r_quo <= DW'(r_dvs);
                            r_dvs <= r_rem;
                        end
                    end
                end
                S_DIVN: begin
                    if (!s_busy) begin
                        r_n     <= r_quo[W-1:0];
                        r_rem   <= '0;
                        r_quo   <= DW'(r_par);
                        r_cnt   <= CW'(DW);
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (!s_busy) begin
                        if (r_n > FIELD_MAX || r_quo[W-1:0] > FIELD_MAX) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_OUT;
                        end else begin
                            r_num   <= r_n[F-1:0];
                            r_den   <= r_quo[F-1:0];
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= (CFG_BITS+F)'(r_min_ratio) * (CFG_BITS+F)'(r_num);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // floor(d / n) < m exactly when d < m * n
                    if ((CFG_BITS+F)'(r_den) < r_prod) begin
                        r_status <= ST_NO_FIT;
                        r_num    <= '0;
                        r_den    <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_RMUL: begin
                    r_rem   <= '0;
                    r_quo   <= DW'(r_par) * DW'(r_num);
                    r_dvs   <= W'(r_den);
                    r_cnt   <= CW'(DW);
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    if (!s_busy) begin
                        if (r_quo > s_limq) begin
                            r_rate   <= RATE_MASK;
                            r_status <= ST_OVERFLOW;
                        end else begin
                            r_rate <= r_quo[W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid          <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.numerator   <= 16'(r_num);
                        r_out.denominator <= 16'(r_den);
                        r_out.packed_word <= (r_status == ST_OK || r_status == ST_OVERFLOW)
                                             ? W'({r_num, r_den}) : '0;
                        r_out.out_rate    <= r_rate;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_GCD || r_state == S_DIVN ||
                           r_state == S_DIVD || r_state == S_RDIV))
        else $error("divider running outside a divide state");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_OVERFLOW))
        else $error("status code out of range");

    a_packed_needs_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.packed_word != '0) |->
        (o_out_data.denominator != '0))
        else $error("packed word with zero denominator");

endmodule

// ===== tb/testbench.sv =====
// Testbench for the fractional divider setting solver: directed table, random traffic, checks.
module testbench;
    import fds_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_req        in_data;
    logic        out_valid;
    logic        out_ready;
    t_res        out_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    fractional_divider_setting_solver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    typedef struct {
        t_req req;
        logic has_exp;
        t_res exp;
    } t_row;

    logic [15:0] min_ratio;
    t_res        expected_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        long_hold_req;
    logic        holding;
    int          idle_cycles;
    t_row        rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res solve_divider(t_req r, logic [15:0] mr);
        t_res        res;
        logic [63:0] x, y, t, n, d, prod;
        res = '0;
        if (r.req_type == REQ_SOLVE) begin
            if (r.target_rate == 0 || r.base_rate == 0) begin
                res.status = ST_ZERO_RATE;
            end else begin
                x = 64'(r.target_rate);
                y = 64'(r.base_rate);
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                n = 64'(r.target_rate) / x;
                d = 64'(r.base_rate) / x;
                if (n > 64'hffff || d > 64'hffff || (d / n) < 64'(mr)) begin
                    res.status = ST_NO_FIT;
                end else begin
                    res.status      = ST_OK;
                    res.numerator   = n[15:0];
                    res.denominator = d[15:0];
                    res.packed_word = {n[15:0], d[15:0]};
                end
            end
        end else if (r.reg_word == 0) begin
            res.status   = ST_OK;
            res.out_rate = r.base_rate;
        end else begin
            res.numerator   = r.reg_word[31:16];
            res.denominator = r.reg_word[15:0];
            if (r.reg_word[15:0] == 0) begin
                res.status = ST_ZERO_DEN;
            end else begin
                prod = (64'(r.base_rate) * 64'(r.reg_word[31:16])) / 64'(r.reg_word[15:0]);
                res.packed_word = r.reg_word;
                if (prod > 64'hffff_ffff) begin
                    res.status   = ST_OVERFLOW;
                    res.out_rate = 32'hffff_ffff;
                end else begin
                    res.status   = ST_OK;
                    res.out_rate = prod[31:0];
                end
            end
        end
        return res;
    endfunction

    function automatic t_req make_req(logic rt, logic [31:0] tr, logic [31:0] pr,
                                      logic [31:0] w);
        t_req r;
        r.req_type    = rt;
        r.target_rate = tr;
        r.base_rate   = pr;
        r.reg_word    = w;
        return r;
    endfunction

    function automatic t_res make_res(logic [2:0] st, logic [15:0] n, logic [15:0] d,
                                      logic [31:0] pw, logic [31:0] ro);
        t_res r;
        r.status      = st;
        r.numerator   = n;
        r.denominator = d;
        r.packed_word = pw;
        r.out_rate    = ro;
        return r;
    endfunction

    // Random request: a mix of solvable ratios, raw noise and varied recalc words.
    function automatic t_req random_req();
        t_req        r;
        logic [31:0] g, n, d;
        r = make_req(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        case ($urandom_range(0, 5)) inside
            0: ;
            1, 2: begin
                n = $urandom_range(1, 300);
                d = n * $urandom_range(1, 40) + $urandom_range(0, n - 1);
                if (d == 0) d = 1;
                g = $urandom_range(1, 60000);
                r.target_rate = n * g;
                r.base_rate   = d * g;
            end
            3: begin
                r.reg_word[31:16] = $urandom_range(0, 3) == 0 ? 16'hffff
                                                              : 16'($urandom_range(0, 16));
                r.reg_word[15:0]  = $urandom_range(0, 3) == 0 ? 16'd0
                                                              : 16'($urandom_range(1, 16));
            end
            4: begin
                r.target_rate = $urandom_range(0, 3);
                r.base_rate   = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
                r.reg_word    = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
            end
            default: begin
                r.target_rate = $urandom_range(1, 65535);
                r.base_rate   = $urandom_range(1, 65535);
            end
        endcase
        return r;
    endfunction

    // Valid stays up after a transfer until the next item or an idle cycle drops it
    task automatic send_req(t_req r);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        expected_q.push_back(solve_divider(r, min_ratio));
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_min_ratio(logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        min_ratio = v;
    endtask

    // Long receiver hold-off, counted here while the sender keeps offering
    initial begin
        holding = 1'b0;
        wait (long_hold_req);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (3000) @(posedge i_clk);
        holding <= 1'b0;
    end

    // Result checker and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    errors = errors + 1;
                end else begin
                    if (out_data !== expected_q[0]) begin
                        $display("%0t: mismatch expected %p actual %p", $time,
                                 expected_q[0], out_data);
                        errors = errors + 1;
                    end
                    void'(expected_q.pop_front());
                end
            end
            if (holding) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int i, ph;
        errors = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b0;
        min_ratio = 16'd20;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        i_rst_n   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: known results where obvious, predictor elsewhere
        rows.push_back('{make_req(REQ_SOLVE, 0, 100, 0), 1,
                         make_res(ST_ZERO_RATE, 0, 0, 0, 0)});
        rows.push_back('{make_req(REQ_SOLVE, 100, 0, 0), 1,
                         make_res(ST_ZERO_RATE, 0, 0, 0, 0)});
        rows.push_back('{make_req(REQ_SOLVE, 1, 20, 0), 1,
                         make_res(ST_OK, 1, 20, 32'h0001_0014, 0)});
        rows.push_back('{make_req(REQ_SOLVE, 1, 19, 0), 1,
                         make_res(ST_NO_FIT, 0, 0, 0, 0)});
        rows.push_back('{make_req(REQ_SOLVE, 1, 65536, 0), 1,
                         make_res(ST_NO_FIT, 0, 0, 0, 0)});
        rows.push_back('{make_req(REQ_SOLVE, 32'hffff_ffff, 32'hffff_ffff, 0), 0, '0});
        rows.push_back('{make_req(REQ_SOLVE, 1000, 48000000, 0), 0, '0});
        rows.push_back('{make_req(REQ_SOLVE, 32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff),
                         0, '0});
        rows.push_back('{make_req(REQ_SOLVE, 3000, 65535000, 0), 0, '0});
        rows.push_back('{make_req(REQ_RECALC, 0, 1234, 0), 1,
                         make_res(ST_OK, 0, 0, 0, 1234)});
        rows.push_back('{make_req(REQ_RECALC, 0, 32'hffff_ffff, 0), 1,
                         make_res(ST_OK, 0, 0, 0, 32'hffff_ffff)});
        rows.push_back('{make_req(REQ_RECALC, 0, 500, 32'h0005_0000), 1,
                         make_res(ST_ZERO_DEN, 5, 0, 0, 0)});
        rows.push_back('{make_req(REQ_RECALC, 0, 32'hffff_ffff, 32'hffff_0001), 1,
                         make_res(ST_OVERFLOW, 16'hffff, 1, 32'hffff_0001, 32'hffff_ffff)});
        rows.push_back('{make_req(REQ_RECALC, 0, 1000, 32'h0001_0001), 1,
                         make_res(ST_OK, 1, 1, 32'h0001_0001, 1000)});
        rows.push_back('{make_req(REQ_RECALC, 0, 0, 32'h0003_0007), 1,
                         make_res(ST_OK, 3, 7, 32'h0003_0007, 0)});
        rows.push_back('{make_req(REQ_RECALC, 0, 24000000, 32'h0001_ffff), 0, '0});
        rows.push_back('{make_req(REQ_RECALC, 32'hffff_ffff, 32'h8000_0000,
                                  32'h0002_0001), 0, '0});
        rows.push_back('{make_req(REQ_RECALC, 0, 32'hffff_ffff, 32'hffff_ffff), 0, '0});
        foreach (rows[k]) begin
            if (rows[k].has_exp && solve_divider(rows[k].req, min_ratio) !== rows[k].exp) begin
                $display("%0t: table row %0d expected %p predictor %p", $time, k,
                         rows[k].exp, solve_divider(rows[k].req, min_ratio));
                errors = errors + 1;
            end
            send_req(rows[k].req);
        end
        drain();

        // min_ratio extremes: zero passes every fit, the top blocks almost all
        write_min_ratio(16'd0);
        send_req(make_req(REQ_SOLVE, 65535, 65535, 0));
        send_req(make_req(REQ_SOLVE, 1, 65535, 0));
        drain();
        write_min_ratio(16'hffff);
        send_req(make_req(REQ_SOLVE, 1, 65535, 0));
        send_req(make_req(REQ_SOLVE, 1, 65534, 0));
        drain();
        write_min_ratio(16'd1);

        // Random phases: idle and stall mixes, new min_ratio between phases
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                3: begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) long_hold_req = 1'b1;
            for (i = 0; i < 280; i++) begin
                send_req(random_req());
                if (i == 140) drain();
            end
            drain();
            case ($urandom_range(0, 3))
                0: write_min_ratio(16'd0);
                1: write_min_ratio(16'd1);
                2: write_min_ratio(16'hffff);
                default: write_min_ratio(16'($urandom_range(0, 64)));
            endcase
        end
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fds_pkg.sv
hdl/fractional_divider_setting_solver.sv
tb/testbench.sv
